>>> design/utf8_name_validator_assert.svh
// Assertion macros used by the name validator top module.
`ifndef UTF8_NAME_VALIDATOR_ASSERT_SVH
`define UTF8_NAME_VALIDATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UTF8NV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utf8 name validator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define UTF8NV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utf8 name validator: next-cycle check failed");

`endif

>>> design/utf8nv_pkg.sv
// Types, codes and code point classifiers for the UTF-8 name validator.
package utf8nv_pkg;

  typedef logic [20:0] cpoint_t;
  typedef logic [2:0]  verdict_t;

  // Verdict codes; the latched error uses the same encoding.
  localparam verdict_t VERDICT_OK      = 3'd0;
  localparam verdict_t VERDICT_EMPTY   = 3'd1;
  localparam verdict_t VERDICT_BAD     = 3'd2;
  localparam verdict_t VERDICT_CONTROL = 3'd3;
  localparam verdict_t VERDICT_SPACE   = 3'd4;
  localparam verdict_t VERDICT_MARK    = 3'd5;

  localparam logic [7:0] CHAR_AT    = 8'h40;
  localparam logic [7:0] CHAR_SLASH = 8'h2f;

  localparam cpoint_t CP_MAX        = 21'h10ffff;
  localparam cpoint_t CP_SURR_LO    = 21'h00d800;
  localparam cpoint_t CP_SURR_HI    = 21'h00dfff;
  localparam cpoint_t CP_LINE_SEP   = 21'h002028;
  localparam cpoint_t CP_PARA_SEP   = 21'h002029;
  localparam cpoint_t CP_IDEO_SPACE = 21'h003000;
  localparam cpoint_t CP_OGHAM      = 21'h001680;
  localparam cpoint_t CP_MATH_SPACE = 21'h00205f;
  localparam cpoint_t CP_NNB_SPACE  = 21'h00202f;
  localparam cpoint_t CP_NB_SPACE   = 21'h0000a0;
  localparam cpoint_t CP_NEL        = 21'h000085;
  localparam cpoint_t CP_C1_HI      = 21'h00009f;
  localparam cpoint_t CP_DEL        = 21'h00007f;
  localparam cpoint_t CP_C0_HI      = 21'h00001f;
  localparam cpoint_t CP_TAB        = 21'h000009;
  localparam cpoint_t CP_CR         = 21'h00000d;
  localparam cpoint_t CP_SPACE      = 21'h000020;
  localparam cpoint_t CP_EN_QUAD    = 21'h002000;
  localparam cpoint_t CP_HAIR_SPACE = 21'h00200a;
  localparam cpoint_t CP_MIN_2BYTE  = 21'h000080;
  localparam cpoint_t CP_MIN_3BYTE  = 21'h000800;
  localparam cpoint_t CP_MIN_4BYTE  = 21'h010000;

  typedef struct packed {
    cpoint_t    partial_point;
    logic [1:0] bytes_pending;
    logic [1:0] sequence_length;
    logic       seen_first_point;
    logic       first_is_space;
    logic       last_is_space;
    verdict_t   latched_error;
    logic       leading_mark_hit;
    logic       at_string_start;
  } dec_state_t;

  localparam dec_state_t STATE_RESET = '{
    partial_point:    '0,
    bytes_pending:    2'd0,
    sequence_length:  2'd0,
    seen_first_point: 1'b0,
    first_is_space:   1'b0,
    last_is_space:    1'b0,
    latched_error:    VERDICT_OK,
    leading_mark_hit: 1'b0,
    at_string_start:  1'b1
  };

  function automatic logic is_space(cpoint_t p);
    return (p >= CP_TAB && p <= CP_CR) || p == CP_SPACE
        || p == CP_NEL || p == CP_NB_SPACE || p == CP_OGHAM
        || (p >= CP_EN_QUAD && p <= CP_HAIR_SPACE) || p == CP_LINE_SEP
        || p == CP_PARA_SEP || p == CP_NNB_SPACE || p == CP_MATH_SPACE
        || p == CP_IDEO_SPACE;
  endfunction

  function automatic logic is_forbidden(cpoint_t p);
    return p <= CP_C0_HI || (p >= CP_DEL && p <= CP_C1_HI)
        || p == CP_LINE_SEP || p == CP_PARA_SEP;
  endfunction

endpackage

>>> design/utf8nv_step.sv
// Per-byte decode: next decoder state and the verdict for a closing item.
module utf8nv_step (
  input  logic                   has_byte,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  input  logic                   forbid_leading_marks,
  input  utf8nv_pkg::dec_state_t st_i,
  output utf8nv_pkg::dec_state_t st_o,
  output logic                   emit,
  output utf8nv_pkg::verdict_t   verdict
);
  import utf8nv_pkg::*;

  dec_state_t s;
  cpoint_t    shifted;
  cpoint_t    point;
  logic       have_point;
  logic       overlong;

  assign shifted = {st_i.partial_point[14:0], data_byte[5:0]};

  always_comb begin
    s          = st_i;
    point      = '0;
    have_point = 1'b0;
    overlong   = 1'b0;

    if (has_byte) begin
      if (st_i.at_string_start) begin
        s.at_string_start  = 1'b0;
        s.leading_mark_hit = forbid_leading_marks &&
                             (data_byte == CHAR_AT || data_byte == CHAR_SLASH);
      end
      if (st_i.latched_error == VERDICT_OK) begin
        if (st_i.bytes_pending == 2'd0) begin
          // Lead byte: ASCII completes a point, otherwise a sequence opens.
          priority if (!data_byte[7]) begin
            point      = {13'd0, data_byte};
            have_point = 1'b1;
          end else if (data_byte[7:5] == 3'b110) begin
            s.sequence_length = 2'd1;
            s.bytes_pending   = 2'd1;
            s.partial_point   = {16'd0, data_byte[4:0]};
          end else if (data_byte[7:4] == 4'b1110) begin
            s.sequence_length = 2'd2;
            s.bytes_pending   = 2'd2;
            s.partial_point   = {17'd0, data_byte[3:0]};
          end else if (data_byte[7:3] == 5'b11110) begin
            s.sequence_length = 2'd3;
            s.bytes_pending   = 2'd3;
            s.partial_point   = {18'd0, data_byte[2:0]};
          end else begin
            s.latched_error = VERDICT_BAD;
          end
        end else if (data_byte[7:6] != 2'b10) begin
          s.latched_error = VERDICT_BAD;
          s.bytes_pending = 2'd0;
        end else begin
          s.partial_point = shifted;
          s.bytes_pending = st_i.bytes_pending - 2'd1;
          if (st_i.bytes_pending == 2'd1) begin
            overlong = (st_i.sequence_length == 2'd1 && shifted < CP_MIN_2BYTE)
                    || (st_i.sequence_length == 2'd2 && shifted < CP_MIN_3BYTE)
                    || (st_i.sequence_length == 2'd3 && shifted < CP_MIN_4BYTE);
            if (overlong || shifted > CP_MAX ||
                (shifted >= CP_SURR_LO && shifted <= CP_SURR_HI)) begin
              s.latched_error = VERDICT_BAD;
            end else begin
              point      = shifted;
              have_point = 1'b1;
            end
          end
        end

        if (have_point) begin
          if (is_forbidden(point)) begin
            s.latched_error = VERDICT_CONTROL;
          end else begin
            if (!st_i.seen_first_point) begin
              s.first_is_space   = is_space(point);
              s.seen_first_point = 1'b1;
            end
            s.last_is_space = is_space(point);
          end
        end
      end
    end

    priority if (s.at_string_start)                 verdict = VERDICT_EMPTY;
    else if (s.latched_error != VERDICT_OK)         verdict = s.latched_error;
    else if (s.bytes_pending != 2'd0)               verdict = VERDICT_BAD;
    else if (s.first_is_space || s.last_is_space)   verdict = VERDICT_SPACE;
    else if (s.leading_mark_hit)                    verdict = VERDICT_MARK;
    else                                            verdict = VERDICT_OK;

    emit = last_byte;
    st_o = last_byte ? STATE_RESET : s;
  end

endmodule

>>> design/utf8nv_out_reg.sv
// Result register with valid and ready toward the consumer.
module utf8nv_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  utf8nv_pkg::verdict_t verdict_in,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output utf8nv_pkg::verdict_t out_verdict
);
  import utf8nv_pkg::*;

  logic     valid_r;
  verdict_t verdict_r;

  // The register can take a new verdict when empty or drained this cycle.
  assign free        = !valid_r || out_ready;
  assign out_valid   = valid_r;
  assign out_verdict = verdict_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      verdict_r <= verdict_in;
    end
  end

endmodule

>>> design/utf8_name_validator.sv
// Strict UTF-8 name validator: one byte per transaction, one verdict per string.
//
// The block checks a name string that arrives one byte per input transaction,
// with in_last_byte marking the final transaction of the string; a final
// transaction with in_has_byte low ends the string without adding a byte, and
// on its own it reports an empty string. Bytes are decoded as they arrive:
// the first error in stream order (malformed UTF-8, a control character or a
// line or paragraph separator) is latched, and later bytes of that string are
// not decoded. One verdict comes out for each string, on the transaction that
// carries in_last_byte: 0 ok, 1 empty, 2 bad UTF-8 (including a sequence left
// unfinished), 3 control or line break, 4 leading or trailing whitespace,
// 5 a leading '@' or '/' while in_forbid_leading_marks was high on the first
// byte. The block sustains one byte per clock cycle. Each transaction is held
// in the input register, where the decoder updates its state, and a verdict
// then sits in the result register until the consumer takes it; the decoder
// state loop closes through the combinational step logic, which sets the rate.
// The input side stalls only while a closing transaction, with or without a
// byte, waits on a full result register that the consumer is not draining.
module utf8_name_validator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_has_byte,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_last_byte,
  input  logic                 in_forbid_leading_marks,
  output logic                 out_valid,
  input  logic                 out_ready,
  output utf8nv_pkg::verdict_t out_verdict
);
  import utf8nv_pkg::*;

  // Input register.
  logic       in_valid_r;
  logic       has_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       forbid_r;

  // Decoder state.
  dec_state_t st_r;
  dec_state_t st_nxt;

  logic       step_emit;
  verdict_t   step_verdict;
  logic       out_free;
  logic       advance;
  logic       in_take;

  // The held transaction retires when it produces no verdict or when the
  // result register can take its verdict.
  assign advance  = in_valid_r && (!step_emit || out_free);
  assign in_ready = !in_valid_r || advance;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      has_r    <= in_has_byte;
      byte_r   <= in_data_byte;
      last_r   <= in_last_byte;
      forbid_r <= in_forbid_leading_marks;
    end
  end

  // The decoder state moves only when a transaction retires; a closing
  // transaction returns it to the string-start state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_RESET;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  utf8nv_step u_step (
    .has_byte             (has_r),
    .data_byte            (byte_r),
    .last_byte            (last_r),
    .forbid_leading_marks (forbid_r),
    .st_i                 (st_r),
    .st_o                 (st_nxt),
    .emit                 (step_emit),
    .verdict              (step_verdict)
  );

  utf8nv_out_reg u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (advance && step_emit),
    .verdict_in  (step_verdict),
    .free        (out_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_verdict (out_verdict)
  );

`include "utf8_name_validator_assert.svh"

  // A latched error always leaves no continuation bytes outstanding.
  `UTF8NV_ASSERT_NOW(a_err_no_pending, st_r.latched_error != VERDICT_OK, st_r.bytes_pending == 2'd0)
  // Outstanding continuation bytes never exceed the sequence length.
  `UTF8NV_ASSERT_NOW(a_pending_le_len, 1'b1, st_r.bytes_pending <= st_r.sequence_length)
  // A verdict leaves the decoder back at the start of a fresh string.
  `UTF8NV_ASSERT_NEXT(a_reset_after_emit, advance && step_emit, st_r.at_string_start && st_r.latched_error == VERDICT_OK)
  // The input side stalls only behind a held transaction and a full result.
  `UTF8NV_ASSERT_NOW(a_stall_cause, !in_ready, in_valid_r && out_valid && last_r)
  // Verdicts stay within the defined codes.
  `UTF8NV_ASSERT_NOW(a_verdict_range, out_valid, out_verdict <= VERDICT_MARK)

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the UTF-8 name validator: random name strings in, verdicts checked.
module tb_top;
  import utf8nv_pkg::*;

  // One input transaction as the driver presents it.
  typedef struct packed {
    logic       has;
    logic [7:0] data;
    logic       last;
    logic       forbid;
  } name_item_t;

  // Decoder state of the scoreboard's own copy of the validator.
  typedef struct {
    cpoint_t    acc;
    logic [1:0] need;
    logic [1:0] seq_len;
    logic       got_first;
    logic       first_ws;
    logic       last_ws;
    verdict_t   err;
    logic       mark_hit;
    logic       fresh;
  } scan_t;

  localparam int RANDOM_ITEMS = 1950;
  localparam int IDLE_PCT     = 34;
  // Both sides run flat out inside this window of cycles.
  localparam int QUIET_FROM   = 1500;
  localparam int QUIET_TO     = 2700;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_has_byte = 1'b0;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       in_forbid_leading_marks = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  verdict_t   out_verdict;

  name_item_t pending_items[$];    // transactions not yet offered to the block
  verdict_t   pending_verdicts[$]; // verdicts predicted but not yet received
  logic [7:0] name_bytes[$];       // scratch buffer for the string being built
  scan_t      scan;
  int         errors = 0;
  int         cycle_count = 0;
  int         active_items = 0;

  utf8_name_validator i_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_has_byte             (in_has_byte),
    .in_data_byte            (in_data_byte),
    .in_last_byte            (in_last_byte),
    .in_forbid_leading_marks (in_forbid_leading_marks),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_verdict             (out_verdict)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // ---------------------------------------------------------------------------
  // Verdict prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_scan();
    scan.acc       = '0;
    scan.need      = 2'd0;
    scan.seq_len   = 2'd0;
    scan.got_first = 1'b0;
    scan.first_ws  = 1'b0;
    scan.last_ws   = 1'b0;
    scan.err       = VERDICT_OK;
    scan.mark_hit  = 1'b0;
    scan.fresh     = 1'b1;
  endfunction

  // Unicode whitespace, as far as the edge-of-name rule is concerned.
  function automatic logic ws_point(cpoint_t p);
    return (p >= CP_TAB && p <= CP_CR) || p == CP_SPACE || p == CP_NEL
        || p == CP_NB_SPACE || p == CP_OGHAM
        || (p >= CP_EN_QUAD && p <= CP_HAIR_SPACE)
        || p == CP_LINE_SEP || p == CP_PARA_SEP || p == CP_NNB_SPACE
        || p == CP_MATH_SPACE || p == CP_IDEO_SPACE;
  endfunction

  // C0 and C1 controls, DEL, and the line and paragraph separators.
  function automatic logic barred_point(cpoint_t p);
    return p <= CP_C0_HI || (p >= CP_DEL && p <= CP_C1_HI)
        || p == CP_LINE_SEP || p == CP_PARA_SEP;
  endfunction

  // A complete, well-formed code point: a barred one latches an error,
  // any other updates the first and last whitespace flags.
  function automatic void land_point(cpoint_t p);
    logic ws;
    if (barred_point(p)) begin
      scan.err = VERDICT_CONTROL;
    end else begin
      ws = ws_point(p);
      if (!scan.got_first) begin
        scan.first_ws  = ws;
        scan.got_first = 1'b1;
      end
      scan.last_ws = ws;
    end
  endfunction

  function automatic void open_seq(logic [1:0] count, cpoint_t bits);
    scan.seq_len = count;
    scan.need    = count;
    scan.acc     = bits;
  endfunction

  function automatic void scan_byte(logic [7:0] b);
    cpoint_t p;
    logic    bad;
    if (scan.need == 2'd0) begin
      // Lead byte position.
      if (!b[7]) land_point({13'd0, b});
      else if (b[7:5] == 3'b110) open_seq(2'd1, {16'd0, b[4:0]});
      else if (b[7:4] == 4'b1110) open_seq(2'd2, {17'd0, b[3:0]});
      else if (b[7:3] == 5'b11110) open_seq(2'd3, {18'd0, b[2:0]});
      else scan.err = VERDICT_BAD;
    end else if (b[7:6] != 2'b10) begin
      scan.err  = VERDICT_BAD;
      scan.need = 2'd0;
    end else begin
      scan.acc  = {scan.acc[14:0], b[5:0]};
      scan.need = scan.need - 2'd1;
      if (scan.need == 2'd0) begin
        p = scan.acc;
        // Overlong forms, values past the Unicode range and surrogates.
        bad = (scan.seq_len == 2'd1 && p < CP_MIN_2BYTE)
           || (scan.seq_len == 2'd2 && p < CP_MIN_3BYTE)
           || (scan.seq_len == 2'd3 && p < CP_MIN_4BYTE)
           || p > CP_MAX || (p >= CP_SURR_LO && p <= CP_SURR_HI);
        if (bad) scan.err = VERDICT_BAD;
        else land_point(p);
      end
    end
  endfunction

  // Advances the predicted state by one accepted transaction and, on the
  // closing transaction of a string, queues the verdict it must produce.
  function automatic void predict_item(logic has, logic [7:0] b, logic last,
                                       logic forbid);
    verdict_t v;
    if (has) begin
      if (scan.fresh) begin
        scan.fresh    = 1'b0;
        scan.mark_hit = forbid && (b == CHAR_AT || b == CHAR_SLASH);
      end
      // Once an error is latched, the rest of the string is not decoded.
      if (scan.err == VERDICT_OK) scan_byte(b);
    end
    if (last) begin
      if (scan.fresh) v = VERDICT_EMPTY;
      else if (scan.err != VERDICT_OK) v = scan.err;
      else if (scan.need != 2'd0) v = VERDICT_BAD;
      else if (scan.first_ws || scan.last_ws) v = VERDICT_SPACE;
      else if (scan.mark_hit) v = VERDICT_MARK;
      else v = VERDICT_OK;
      pending_verdicts.push_back(v);
      clear_scan();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver and monitor
  // ---------------------------------------------------------------------------

  // Random idle decision shared by both sides, suppressed in the quiet window.
  function automatic logic side_idles();
    if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  // The driver predicts at the edge where a transaction is taken, then either
  // offers the next queued transaction or drops valid. A payload is only
  // replaced once the previous one has been accepted, so valid and payload
  // stay stable while the block stalls.
  always @(posedge clk) begin : drive_inputs
    name_item_t nxt;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_item(in_has_byte, in_data_byte, in_last_byte, in_forbid_leading_marks);
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && !side_idles()) begin
          nxt = pending_items.pop_front();
          in_valid                <= 1'b1;
          in_has_byte             <= nxt.has;
          in_data_byte            <= nxt.data;
          in_last_byte            <= nxt.last;
          in_forbid_leading_marks <= nxt.forbid;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The monitor compares every verdict taken with the oldest prediction and
  // throttles out_ready at random.
  always @(posedge clk) begin : check_verdicts
    verdict_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_verdicts.size() == 0) begin
          $display("%0t: unexpected verdict, expected none, actual %0d", $time, out_verdict);
          errors++;
        end else begin
          want = pending_verdicts.pop_front();
          if (out_verdict !== want) begin
            $display("%0t: verdict mismatch, expected %0d, actual %0d",
                     $time, want, out_verdict);
            errors++;
          end
        end
      end
      out_ready <= !side_idles();
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic push_item(logic has, logic [7:0] data, logic last, logic forbid);
    name_item_t it;
    it.has    = has;
    it.data   = data;
    it.last   = last;
    it.forbid = forbid;
    pending_items.push_back(it);
    // Transactions that are neither a byte nor a string end are just skipped.
    if (has || last) active_items++;
  endtask

  function automatic int natural_len(cpoint_t cp);
    if (cp < CP_MIN_2BYTE) return 1;
    if (cp < CP_MIN_3BYTE) return 2;
    if (cp < CP_MIN_4BYTE) return 3;
    return 4;
  endfunction

  // Appends cp encoded in n bytes; n larger than needed gives an overlong form.
  task automatic encode_point(cpoint_t cp, int n);
    case (n)
      1: name_bytes.push_back({1'b0, cp[6:0]});
      2: begin
        name_bytes.push_back({3'b110, cp[10:6]});
        name_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        name_bytes.push_back({4'b1110, cp[15:12]});
        name_bytes.push_back({2'b10, cp[11:6]});
        name_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        name_bytes.push_back({5'b11110, cp[20:18]});
        name_bytes.push_back({2'b10, cp[17:12]});
        name_bytes.push_back({2'b10, cp[11:6]});
        name_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // Turns name_bytes into transactions. The string either closes on its last
  // byte or with a separate byteless closing transaction; an empty buffer
  // makes an empty string. Skipped transactions are sprinkled in at random.
  task automatic queue_name(bit closing_empty, bit forbid_first);
    int i;
    if (name_bytes.size() == 0) begin
      push_item(1'b0, 8'($urandom_range(255)), 1'b1, forbid_first);
    end else begin
      for (i = 0; i < name_bytes.size(); i++) begin
        if ($urandom_range(99) < 3) begin
          push_item(1'b0, 8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
        end
        push_item(1'b1, name_bytes[i],
                  (i == name_bytes.size() - 1) && !closing_empty,
                  (i == 0) ? forbid_first : 1'($urandom_range(1)));
      end
      if (closing_empty) begin
        push_item(1'b0, 8'($urandom_range(255)), 1'b1, 1'($urandom_range(1)));
      end
    end
    name_bytes.delete();
  endtask

  function automatic cpoint_t pick_space();
    int k;
    k = $urandom_range(22);
    if (k <= 4) return CP_TAB + cpoint_t'(k);
    if (k == 5) return CP_SPACE;
    if (k == 6) return CP_NEL;
    if (k == 7) return CP_NB_SPACE;
    if (k == 8) return CP_OGHAM;
    if (k <= 19) return CP_EN_QUAD + cpoint_t'(k - 9);
    if (k == 20) return CP_NNB_SPACE;
    if (k == 21) return CP_MATH_SPACE;
    return CP_IDEO_SPACE;
  endfunction

  // Most strings are clean: drawn only from the printable, space and multi-byte ranges.
  // The rest mix in controls, separators, surrogates, overlong and out-of-range
  // forms, stray bytes and cut-off sequences.
  task automatic queue_random_name();
    int      npts;
    int      cls;
    int      n;
    int      i;
    bit      clean;
    cpoint_t cp;
    clean = $urandom_range(99) < 60;
    npts = ($urandom_range(99) < 70) ? $urandom_range(1, 4) : $urandom_range(5, 12);
    if ($urandom_range(99) < 5) npts = 0;
    for (i = 0; i < npts; i++) begin
      cls = clean ? $urandom_range(82) : $urandom_range(99);
      if (i == 0 && $urandom_range(3) == 0) cls = 100;
      if (cls == 100) begin
        encode_point({13'd0, ($urandom_range(1) != 0) ? CHAR_AT : CHAR_SLASH}, 1);
      end else if (cls < 35) begin
        encode_point(cpoint_t'($urandom_range(8'h21, 8'h7e)), 1);
      end else if (cls < 45) begin
        cp = pick_space();
        encode_point(cp, natural_len(cp));
      end else if (cls < 60) begin
        encode_point(cpoint_t'($urandom_range(21'h80, 21'h7ff)), 2);
      end else if (cls < 73) begin
        encode_point(cpoint_t'($urandom_range(21'h800, 21'hffff)), 3);
      end else if (cls < 83) begin
        encode_point(cpoint_t'($urandom_range(21'h10000, 21'h10ffff)), 4);
      end else if (cls < 87) begin
        cp = ($urandom_range(1) != 0) ? cpoint_t'($urandom_range(21'h0, 21'h1f))
                                      : cpoint_t'($urandom_range(21'h7f, 21'h9f));
        encode_point(cp, natural_len(cp));
      end else if (cls < 89) begin
        encode_point(CP_LINE_SEP + cpoint_t'($urandom_range(1)), 3);
      end else if (cls < 91) begin
        encode_point(cpoint_t'($urandom_range(21'hd800, 21'hdfff)), 3);
      end else if (cls < 93) begin
        cp = cpoint_t'($urandom_range(21'h0, 21'hffff));
        n = natural_len(cp);
        if (n < 4) n = $urandom_range(n + 1, 4);
        encode_point(cp, n);
      end else if (cls < 95) begin
        encode_point(cpoint_t'($urandom_range(21'h110000, 21'h1fffff)), 4);
      end else if (cls < 98) begin
        name_bytes.push_back(8'($urandom_range(255)));
      end else begin
        cp = cpoint_t'($urandom_range(21'h80, 21'h10ffff));
        n = natural_len(cp);
        encode_point(cp, n);
        repeat ($urandom_range(1, n - 1)) void'(name_bytes.pop_back());
      end
    end
    queue_name($urandom_range(99) < 12, 1'($urandom_range(1)));
  endtask

  initial begin : stimulus
    int base;
    clear_scan();

    // Directed strings first.
    queue_name(1'b0, 1'b0);                          // empty string
    name_bytes = '{8'h41};             queue_name(1'b0, 1'b1);  // plain letter
    name_bytes = '{CHAR_AT};           queue_name(1'b0, 1'b1);  // forbidden leading mark
    name_bytes = '{CHAR_SLASH, 8'h78}; queue_name(1'b0, 1'b0);  // mark allowed
    name_bytes = '{8'h00};             queue_name(1'b0, 1'b0);  // lowest byte, a control
    name_bytes = '{8'hff};             queue_name(1'b0, 1'b0);  // highest byte, bad lead
    name_bytes = '{8'h20};             queue_name(1'b0, 1'b0);  // lone space
    name_bytes = '{8'hc0, 8'h80};      queue_name(1'b0, 1'b0);  // overlong NUL
    name_bytes = '{8'hed, 8'ha0, 8'h80};        queue_name(1'b0, 1'b0);  // surrogate
    name_bytes = '{8'hf4, 8'h90, 8'h80, 8'h80}; queue_name(1'b0, 1'b0);  // above range
    name_bytes = '{8'he2, 8'h82};      queue_name(1'b1, 1'b0);  // cut off, byteless close
    push_item(1'b0, 8'hff, 1'b0, 1'b1);                         // skipped transaction
    name_bytes = '{8'h62};             queue_name(1'b0, 1'b0);
    name_bytes = '{8'he2, 8'h80, 8'ha8};        queue_name(1'b0, 1'b0);  // line separator

    base = active_items;
    while (active_items - base < RANDOM_ITEMS) queue_random_name();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every transaction to be taken and every verdict to come back,
    // then keep watching for any stray verdict before reporting.
    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
